// ----- hdl/tlca_pkg.sv -----
// Shared constants for the tree lowest-common-ancestor block.
package tlca_pkg;

  // Node identifiers and depths are 12 bits wide.
  localparam int ID_W = 12;

  // The root node, fixed at reset.
  localparam logic [ID_W-1:0] ROOT_ID = 12'd1;

  // Depths saturate at this value.
  localparam logic [ID_W-1:0] DEPTH_MAX = 12'hFFF;

  // Item function codes.
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

endpackage

// ----- hdl/tlca_slot.sv -----
// Two-stage unit that maps a node id onto its table row (id modulo MAX_NODES).
module tlca_slot #(
  parameter int MAX_NODES = 4096,
  localparam int AW = $clog2(MAX_NODES)
) (
  input  logic                      clk,
  input  logic [tlca_pkg::ID_W-1:0] id,
  output logic [AW-1:0]             slot
);

  // Reciprocal scaled by 2^24; the quotient estimate is low by at most one.
  localparam int RSH = 24;
  localparam logic [23:0] RECIP = 24'((64'd1 << RSH) / MAX_NODES);
  localparam logic [28:0] MODV  = 29'(MAX_NODES);

  logic [35:0]               prod1;
  logic [tlca_pkg::ID_W-1:0] q_r;
  logic [tlca_pkg::ID_W-1:0] id_d_r;
  logic [28:0]               prod2;
  logic [28:0]               rem;
  logic [28:0]               rem_fix;
  logic [AW-1:0]             slot_r;

  // First stage: quotient estimate.
  assign prod1 = 36'(id) * 36'(RECIP);

  always_ff @(posedge clk) begin
    q_r    <= prod1[35:24];
    id_d_r <= id;
  end

  // Second stage: remainder with a single correction step.
  assign prod2   = 29'(q_r) * MODV;
  assign rem     = 29'(id_d_r) - prod2;
  assign rem_fix = (rem >= MODV) ? (rem - MODV) : rem;

  always_ff @(posedge clk) begin
    slot_r <= rem_fix[AW-1:0];
  end

  assign slot = slot_r;

endmodule

// ----- hdl/tlca_depth_mem.sv -----
// Node depth memory: one write port, two registered read ports, root default.
module tlca_depth_mem #(
  parameter int MAX_NODES = 4096,
  localparam int AW = $clog2(MAX_NODES)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_slot,
  input  logic [tlca_pkg::ID_W-1:0] wr_data,
  input  logic [AW-1:0]             rd0_slot,
  output logic [tlca_pkg::ID_W-1:0] rd0_data,
  input  logic [AW-1:0]             rd1_slot,
  output logic [tlca_pkg::ID_W-1:0] rd1_data
);

  localparam logic [AW-1:0] ROOT_SLOT = AW'(tlca_pkg::ROOT_ID);

  logic [tlca_pkg::ID_W-1:0] mem [MAX_NODES];
  logic [tlca_pkg::ID_W-1:0] q0_r;
  logic [tlca_pkg::ID_W-1:0] q1_r;
  logic                      dflt0_r;
  logic                      dflt1_r;
  logic                      root_wr_r;

  // Storage array with registered reads.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot] <= wr_data;
    end
    q0_r <= mem[rd0_slot];
    q1_r <= mem[rd1_slot];
  end

  // The root entry reads as depth zero until some add overwrites it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_wr_r <= 1'b0;
    end else if (wr_en && (wr_slot == ROOT_SLOT)) begin
      root_wr_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    dflt0_r <= (rd0_slot == ROOT_SLOT) && !root_wr_r;
    dflt1_r <= (rd1_slot == ROOT_SLOT) && !root_wr_r;
  end

  assign rd0_data = dflt0_r ? '0 : q0_r;
  assign rd1_data = dflt1_r ? '0 : q1_r;

endmodule

// ----- hdl/tlca_anc_mem.sv -----
// Ancestor table memory: one write port, two registered read ports, root row default.
module tlca_anc_mem #(
  parameter int MAX_NODES  = 4096,
  parameter int LOG_LEVELS = 12,
  localparam int AW = $clog2(MAX_NODES),
  localparam int LW = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1,
  localparam int EW = tlca_pkg::ID_W + AW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_slot,
  input  logic [LW-1:0] wr_lvl,
  input  logic [EW-1:0] wr_data,
  input  logic [AW-1:0] ra_slot,
  input  logic [LW-1:0] ra_lvl,
  output logic [EW-1:0] ra_data,
  input  logic [AW-1:0] rb_slot,
  input  logic [LW-1:0] rb_lvl,
  output logic [EW-1:0] rb_data
);

  localparam int DEPTH = MAX_NODES * LOG_LEVELS;
  localparam int ADW   = $clog2(DEPTH);
  localparam logic [AW-1:0] ROOT_SLOT  = AW'(tlca_pkg::ROOT_ID);
  localparam logic [EW-1:0] ROOT_ENTRY = {ROOT_SLOT, tlca_pkg::ROOT_ID};

  logic [EW-1:0]         mem [DEPTH];
  logic [ADW-1:0]        wa;
  logic [ADW-1:0]        raa;
  logic [ADW-1:0]        rba;
  logic [EW-1:0]         qa_r;
  logic [EW-1:0]         qb_r;
  logic [EW-1:0]         wdata_r;
  logic                  fwd_a_r;
  logic                  fwd_b_r;
  logic                  dflt_a_r;
  logic                  dflt_b_r;
  logic [LOG_LEVELS-1:0] root_wr_r;

  // Row-major addressing: row = slot, column = level.
  assign wa  = ADW'(32'(wr_slot) * 32'(LOG_LEVELS) + 32'(wr_lvl));
  assign raa = ADW'(32'(ra_slot) * 32'(LOG_LEVELS) + 32'(ra_lvl));
  assign rba = ADW'(32'(rb_slot) * 32'(LOG_LEVELS) + 32'(rb_lvl));

  // Storage array; reads return the old contents on a same-cycle write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wa] <= wr_data;
    end
    qa_r <= mem[raa];
    qb_r <= mem[rba];
  end

  // Root row entries read as the root itself until overwritten.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_wr_r <= '0;
    end else if (wr_en && (wr_slot == ROOT_SLOT)) begin
      root_wr_r[wr_lvl] <= 1'b1;
    end
  end

  // Forwarding of a write to a read of the same entry in the same cycle.
  always_ff @(posedge clk) begin
    wdata_r  <= wr_data;
    fwd_a_r  <= wr_en && (wa == raa);
    fwd_b_r  <= wr_en && (wa == rba);
    dflt_a_r <= (ra_slot == ROOT_SLOT) && !root_wr_r[ra_lvl];
    dflt_b_r <= (rb_slot == ROOT_SLOT) && !root_wr_r[rb_lvl];
  end

  assign ra_data = fwd_a_r ? wdata_r : (dflt_a_r ? ROOT_ENTRY : qa_r);
  assign rb_data = fwd_b_r ? wdata_r : (dflt_b_r ? ROOT_ENTRY : qb_r);

endmodule

// ----- hdl/tree_lca_binary_lifting.sv -----
// Top level: sequencer for tree growth and lowest-common-ancestor queries.
//
// Usage: one input channel (in_valid / in_stall) carries items of in_func,
// in_node_a and in_node_b. An add item (func 0) hangs node_b under parent
// node_a and gives no result. A query item (func 1) gives one result on the
// output channel (out_valid / out_stall): the lowest common ancestor of the
// two nodes. Node 1 is the root.
// Items are handled one at a time; in_stall is high while one is in work.
// An add whose child is the root is ignored and gives no result.
// A query's result appears in the same cycle that the next item can be taken.
// Query time is set by the chain of dependent ancestor-table reads, each a
// registered memory read, one level after another.
// A finished result sits in the output register while the next item is taken;
// if the receiver stalls and a second result is ready, the sequencer waits.
// Reset is synchronous and active low. After reset only the root exists; the
// root's depth and ancestor row come from reset defaults, and the memories
// need no clearing pass.
module tree_lca_binary_lifting #(
  parameter int MAX_NODES  = 4096,
  parameter int LOG_LEVELS = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_func,
  input  logic [tlca_pkg::ID_W-1:0] in_node_a,
  input  logic [tlca_pkg::ID_W-1:0] in_node_b,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [tlca_pkg::ID_W-1:0] out_ancestor_node
);

  localparam int IW = tlca_pkg::ID_W;
  localparam int AW = $clog2(MAX_NODES);
  localparam int LW = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
  localparam int EW = IW + AW;
  localparam logic [LW-1:0] LVL_LAST = LW'(LOG_LEVELS - 1);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SL1   = 4'd1;
  localparam logic [3:0] ST_SL2   = 4'd2;
  localparam logic [3:0] ST_START = 4'd3;
  localparam logic [3:0] ST_ADEP  = 4'd4;
  localparam logic [3:0] ST_AWR   = 4'd5;
  localparam logic [3:0] ST_ARD   = 4'd6;
  localparam logic [3:0] ST_QDEP  = 4'd7;
  localparam logic [3:0] ST_LIFT  = 4'd8;
  localparam logic [3:0] ST_LIFTW = 4'd9;
  localparam logic [3:0] ST_CMP   = 4'd10;
  localparam logic [3:0] ST_SRCH  = 4'd11;
  localparam logic [3:0] ST_SRCHW = 4'd12;
  localparam logic [3:0] ST_FIN   = 4'd13;
  localparam logic [3:0] ST_FINW  = 4'd14;
  localparam logic [3:0] ST_OUT   = 4'd15;

  logic [3:0]    state_r, state_nxt;
  logic          func_r;
  logic [IW-1:0] a_id_r;
  logic [IW-1:0] b_id_r;
  logic [AW-1:0] a_slot;
  logic [AW-1:0] b_slot;
  logic [IW-1:0] u_id_r, u_id_nxt;
  logic [AW-1:0] u_slot_r, u_slot_nxt;
  logic [IW-1:0] v_id_r, v_id_nxt;
  logic [AW-1:0] v_slot_r, v_slot_nxt;
  logic [AW-1:0] c_slot_r, c_slot_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;
  logic [IW-1:0] gap_r, gap_nxt;
  logic [IW-1:0] res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [IW-1:0] out_node_r;
  logic          in_xfer;
  logic          out_free;
  logic          out_load;
  logic [16:0]   step;
  logic          take;

  // Memory port signals.
  logic          anc_we;
  logic [EW-1:0] anc_wdata;
  logic [EW-1:0] ra_data;
  logic [EW-1:0] rb_data;
  logic [IW-1:0] ra_id;
  logic [AW-1:0] ra_slot_f;
  logic [IW-1:0] rb_id;
  logic [AW-1:0] rb_slot_f;
  logic          dep_we;
  logic [IW-1:0] dep_wdata;
  logic [IW-1:0] d0_data;
  logic [IW-1:0] d1_data;

  // Row mapping of both input ids.
  tlca_slot #(.MAX_NODES(MAX_NODES)) u_slot_a (
    .clk  (clk),
    .id   (a_id_r),
    .slot (a_slot)
  );

  tlca_slot #(.MAX_NODES(MAX_NODES)) u_slot_b (
    .clk  (clk),
    .id   (b_id_r),
    .slot (b_slot)
  );

  // Depth store.
  tlca_depth_mem #(.MAX_NODES(MAX_NODES)) u_depth (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (dep_we),
    .wr_slot  (c_slot_r),
    .wr_data  (dep_wdata),
    .rd0_slot (a_slot),
    .rd0_data (d0_data),
    .rd1_slot (b_slot),
    .rd1_data (d1_data)
  );

  // Ancestor table; both read ports follow the current node pair and level.
  tlca_anc_mem #(.MAX_NODES(MAX_NODES), .LOG_LEVELS(LOG_LEVELS)) u_anc (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (anc_we),
    .wr_slot (c_slot_r),
    .wr_lvl  (lvl_r),
    .wr_data (anc_wdata),
    .ra_slot (u_slot_r),
    .ra_lvl  (lvl_r),
    .ra_data (ra_data),
    .rb_slot (v_slot_r),
    .rb_lvl  (lvl_r),
    .rb_data (rb_data)
  );

  assign anc_wdata = {u_slot_r, u_id_r};
  assign ra_id     = ra_data[IW-1:0];
  assign ra_slot_f = ra_data[EW-1:IW];
  assign rb_id     = rb_data[IW-1:0];
  assign rb_slot_f = rb_data[EW-1:IW];

  // The child's depth is one more than the parent's, saturating.
  assign dep_wdata = (d0_data == tlca_pkg::DEPTH_MAX) ? d0_data : (d0_data + IW'(1));

  // Greedy lift step for the current level.
  assign step = 17'(1) << lvl_r;
  assign take = (17'(gap_r) >= step);

  // Handshake terms.
  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == ST_OUT) && out_free;

  // Sequencer next-state and datapath.
  always_comb begin
    state_nxt  = state_r;
    u_id_nxt   = u_id_r;
    u_slot_nxt = u_slot_r;
    v_id_nxt   = v_id_r;
    v_slot_nxt = v_slot_r;
    c_slot_nxt = c_slot_r;
    lvl_nxt    = lvl_r;
    gap_nxt    = gap_r;
    res_nxt    = res_r;
    anc_we     = 1'b0;
    dep_we     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SL1;
        end
      end
      ST_SL1: begin
        state_nxt = ST_SL2;
      end
      ST_SL2: begin
        state_nxt = ST_START;
      end
      ST_START: begin
        u_id_nxt   = a_id_r;
        u_slot_nxt = a_slot;
        v_id_nxt   = b_id_r;
        v_slot_nxt = b_slot;
        c_slot_nxt = b_slot;
        lvl_nxt    = '0;
        if (func_r == tlca_pkg::FUNC_QUERY) begin
          state_nxt = ST_QDEP;
        end else if (b_id_r == tlca_pkg::ROOT_ID) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_ADEP;
        end
      end
      ST_ADEP: begin
        dep_we    = 1'b1;
        state_nxt = ST_AWR;
      end
      ST_AWR: begin
        anc_we    = 1'b1;
        state_nxt = ST_ARD;
      end
      ST_ARD: begin
        u_id_nxt   = ra_id;
        u_slot_nxt = ra_slot_f;
        if (lvl_r == LVL_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          lvl_nxt   = lvl_r + LW'(1);
          state_nxt = ST_AWR;
        end
      end
      ST_QDEP: begin
        lvl_nxt = LVL_LAST;
        if (d0_data < d1_data) begin
          u_id_nxt   = v_id_r;
          u_slot_nxt = v_slot_r;
          v_id_nxt   = u_id_r;
          v_slot_nxt = u_slot_r;
          gap_nxt    = d1_data - d0_data;
        end else begin
          gap_nxt    = d0_data - d1_data;
        end
        state_nxt = ST_LIFT;
      end
      ST_LIFT: begin
        if (take) begin
          gap_nxt   = gap_r - step[IW-1:0];
          state_nxt = ST_LIFTW;
        end else if (lvl_r == '0) begin
          state_nxt = ST_CMP;
        end else begin
          lvl_nxt = lvl_r - LW'(1);
        end
      end
      ST_LIFTW: begin
        u_id_nxt   = ra_id;
        u_slot_nxt = ra_slot_f;
        if (lvl_r == '0) begin
          state_nxt = ST_CMP;
        end else begin
          lvl_nxt   = lvl_r - LW'(1);
          state_nxt = ST_LIFT;
        end
      end
      ST_CMP: begin
        if (u_id_r == v_id_r) begin
          res_nxt   = u_id_r;
          state_nxt = ST_OUT;
        end else begin
          lvl_nxt   = LVL_LAST;
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        state_nxt = ST_SRCHW;
      end
      ST_SRCHW: begin
        if (ra_id != rb_id) begin
          u_id_nxt   = ra_id;
          u_slot_nxt = ra_slot_f;
          v_id_nxt   = rb_id;
          v_slot_nxt = rb_slot_f;
        end
        if (lvl_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          lvl_nxt   = lvl_r - LW'(1);
          state_nxt = ST_SRCH;
        end
      end
      ST_FIN: begin
        state_nxt = ST_FINW;
      end
      ST_FINW: begin
        res_nxt   = ra_id;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid holds until the receiver takes the transfer.
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lvl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lvl_r       <= lvl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_r <= in_func;
      a_id_r <= in_node_a;
      b_id_r <= in_node_b;
    end
    if (out_load) begin
      out_node_r <= res_r;
    end
    u_id_r   <= u_id_nxt;
    u_slot_r <= u_slot_nxt;
    v_id_r   <= v_id_nxt;
    v_slot_r <= v_slot_nxt;
    c_slot_r <= c_slot_nxt;
    gap_r    <= gap_nxt;
    res_r    <= res_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_ancestor_node = out_node_r;

`ifndef SYNTHESIS
  // The level counter never points past the last table column.
  a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
    lvl_r <= LVL_LAST)
    else $error("level counter out of range");

  // The ancestor table is written only while an add is in work.
  a_write_on_add: assert property (@(posedge clk) disable iff (!rst_n)
    anc_we |-> (func_r == tlca_pkg::FUNC_ADD))
    else $error("ancestor table written during a query");

  // A pending result is never overwritten while the receiver stalls.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_valid_r && out_stall) |=> (state_r == ST_OUT))
    else $error("result dropped under stall");

  // An add of the root as a child leaves the tables alone.
  a_root_add: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_START && func_r == tlca_pkg::FUNC_ADD &&
     b_id_r == tlca_pkg::ROOT_ID) |=> (state_r == ST_IDLE))
    else $error("root entry modified by an add");
`endif

endmodule

// ----- tb/tlca_checker.sv -----
// Checker for the tree LCA block: tracks the tree, predicts each ancestor result and compares.
module tlca_checker #(
  parameter int NODES  = 4096,
  parameter int LEVELS = 12,
  localparam int IW = tlca_pkg::ID_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  logic          in_func,
  input  logic [IW-1:0] in_node_a,
  input  logic [IW-1:0] in_node_b,
  input  logic          out_valid,
  input  logic          out_stall,
  input  logic [IW-1:0] out_ancestor_node,
  output int            mismatches,
  output int            compared,
  output int            waiting
);

  // Our own copy of the tree: 2^k-th ancestors and depth per node.
  logic [IW-1:0] lift_tbl [NODES][LEVELS];
  logic [IW-1:0] depth_of [NODES];

  // Ancestors still owed by the block, oldest first.
  logic [IW-1:0] lca_due [$];

  // After reset only the root exists, and it is its own ancestor.
  task automatic clear_tree();
    for (int n = 0; n < NODES; n++) begin
      for (int l = 0; l < LEVELS; l++) begin
        lift_tbl[n][l] = '0;
      end
      depth_of[n] = '0;
    end
    for (int l = 0; l < LEVELS; l++) begin
      lift_tbl[tlca_pkg::ROOT_ID][l] = tlca_pkg::ROOT_ID;
    end
    depth_of[tlca_pkg::ROOT_ID] = '0;
  endtask

  // Hang child under parent. The ancestor row is filled level by level, so a
  // node added under itself ends up its own ancestor everywhere.
  task automatic graft_node(input logic [IW-1:0] parent, input logic [IW-1:0] child);
    logic [IW-1:0] d;
    logic [IW-1:0] hop;
    if (child != tlca_pkg::ROOT_ID) begin
      d = depth_of[parent];
      if (d != tlca_pkg::DEPTH_MAX) begin
        d = d + 1'b1;
      end
      depth_of[child] = d;
      hop = parent;
      for (int i = 0; i < LEVELS; i++) begin
        lift_tbl[child][i] = hop;
        hop = lift_tbl[hop][i];
      end
    end
  endtask

  // Lift the deeper node to the other's depth, then lift both while they differ.
  function automatic logic [IW-1:0] common_ancestor(input logic [IW-1:0] a,
                                                    input logic [IW-1:0] b);
    logic [IW-1:0] u;
    logic [IW-1:0] v;
    logic [IW-1:0] un;
    logic [IW-1:0] vn;
    int du;
    int dv;
    int gap;
    u  = a;
    v  = b;
    du = int'(depth_of[a]);
    dv = int'(depth_of[b]);
    if (du < dv) begin
      u   = b;
      v   = a;
      gap = dv - du;
    end else begin
      gap = du - dv;
    end
    for (int k = LEVELS - 1; k >= 0; k--) begin
      if (gap >= (1 << k)) begin
        u   = lift_tbl[u][k];
        gap = gap - (1 << k);
      end
    end
    if (u == v) begin
      return u;
    end
    for (int k = LEVELS - 1; k >= 0; k--) begin
      un = lift_tbl[u][k];
      vn = lift_tbl[v][k];
      if (un != vn) begin
        u = un;
        v = vn;
      end
    end
    return lift_tbl[u][0];
  endfunction

  // Results are checked before new items are taken in, since a result never
  // belongs to a query accepted at the same edge.
  always @(posedge clk) begin : watch
    logic [IW-1:0] want;
    if (!rst_n) begin
      clear_tree();
      lca_due.delete();
      mismatches = 0;
      compared   = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (lca_due.size() == 0) begin
          mismatches++;
          $display("%0t: ancestor result %0d transferred with no query outstanding",
                    $time, out_ancestor_node);
        end else begin
          want = lca_due.pop_front();
          compared++;
          if (out_ancestor_node !== want) begin
            mismatches++;
            $display("%0t: ancestor_node mismatch, expected %0d, actual %0d",
                     $time, want, out_ancestor_node);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_func == tlca_pkg::FUNC_QUERY) begin
          lca_due.insert(lca_due.size(), common_ancestor(in_node_a, in_node_b));
        end else begin
          graft_node(in_node_a, in_node_b);
        end
      end
    end
    waiting = lca_due.size();
  end

endmodule

// ----- tb/tree_lca_binary_lifting_tb.sv -----
// Testbench top for the tree LCA block: stimulus, stalls, watchdog and verdict.
module tree_lca_binary_lifting_tb;

  localparam int IW             = tlca_pkg::ID_W;
  localparam int TREE_NODES     = 4096;
  localparam int TREE_LEVELS    = 12;
  localparam int RANDOM_ITEMS   = 320;
  localparam int CHAIN_LEN      = 150;
  localparam int SELF_ADDS      = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4 * TREE_LEVELS + 20;

  logic          clk;
  logic          rst_n             = 1'b0;
  logic          in_valid          = 1'b0;
  logic          in_stall;
  logic          in_func           = tlca_pkg::FUNC_ADD;
  logic [IW-1:0] in_node_a         = tlca_pkg::ROOT_ID;
  logic [IW-1:0] in_node_b         = tlca_pkg::ROOT_ID;
  logic          out_valid;
  logic          out_stall         = 1'b0;
  logic [IW-1:0] out_ancestor_node;

  int mismatches;
  int compared;
  int waiting;
  int adds_sent    = 0;
  int queries_sent = 0;
  int idle_cycles  = 0;
  bit steady       = 1'b0;

  // Which nodes exist, so that no query or add ever reads an unwritten entry.
  bit            present   [TREE_NODES];
  logic [IW-1:0] parent_of [TREE_NODES];
  logic [IW-1:0] members   [$];

  tree_lca_binary_lifting #(
    .MAX_NODES (TREE_NODES),
    .LOG_LEVELS(TREE_LEVELS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_node_a        (in_node_a),
    .in_node_b        (in_node_b),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ancestor_node(out_ancestor_node)
  );

  tlca_checker #(
    .NODES (TREE_NODES),
    .LEVELS(TREE_LEVELS)
  ) checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_node_a        (in_node_a),
    .in_node_b        (in_node_b),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ancestor_node(out_ancestor_node),
    .mismatches       (mismatches),
    .compared         (compared),
    .waiting          (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The receiver stalls at random, except during the steady stretch.
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 17);
  end

  // Watchdog: too long without any transfer on either channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One item on the input channel, with random idle cycles ahead of it outside the steady stretch.
  task automatic send_item(input logic f, input logic [IW-1:0] a,
                           input logic [IW-1:0] b);
    while (!steady && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_func   <= f;
    in_node_a <= a;
    in_node_b <= b;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    if (f == tlca_pkg::FUNC_QUERY) begin
      queries_sent++;
    end else begin
      adds_sent++;
    end
  endtask

  // Add a node and keep the list of existing nodes current.
  task automatic plant(input logic [IW-1:0] parent, input logic [IW-1:0] child);
    send_item(tlca_pkg::FUNC_ADD, parent, child);
    if (child != tlca_pkg::ROOT_ID) begin
      parent_of[child] = parent;
      if (!present[child]) begin
        present[child] = 1'b1;
        members.insert(members.size(), child);
      end
    end
  endtask

  task automatic ask(input logic [IW-1:0] a, input logic [IW-1:0] b);
    send_item(tlca_pkg::FUNC_QUERY, a, b);
  endtask

  function automatic logic [IW-1:0] fresh_id();
    logic [IW-1:0] id;
    do begin
      id = IW'($urandom_range(2, TREE_NODES - 1));
    end while (present[id]);
    return id;
  endfunction

  function automatic logic [IW-1:0] member_any();
    return members[$urandom_range(0, members.size() - 1)];
  endfunction

  // Recently added nodes tend to be deep, so picking them grows long paths.
  function automatic logic [IW-1:0] member_recent();
    int span;
    span = (members.size() < 8) ? members.size() : 8;
    return members[members.size() - 1 - $urandom_range(0, span - 1)];
  endfunction

  function automatic logic [IW-1:0] climb(input logic [IW-1:0] n, input int steps);
    logic [IW-1:0] at;
    at = n;
    for (int j = 0; j < steps; j++) begin
      at = parent_of[at];
    end
    return at;
  endfunction

  initial begin
    logic [IW-1:0] qa;
    logic [IW-1:0] qb;
    logic [IW-1:0] tail;
    logic [IW-1:0] kid;
    logic [IW-1:0] grandkid;
    logic [IW-1:0] chain [$];
    int r;

    for (int n = 0; n < TREE_NODES; n++) begin
      present[n]   = 1'b0;
      parent_of[n] = tlca_pkg::ROOT_ID;
    end
    present[tlca_pkg::ROOT_ID] = 1'b1;
    members.insert(members.size(), tlca_pkg::ROOT_ID);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme ids, root queries, ignored root add, re-parenting and
    // a node added under itself.
    plant(tlca_pkg::ROOT_ID, 12'd4095);
    plant(12'd4095, 12'd2);
    plant(12'd2, 12'd2048);
    plant(tlca_pkg::ROOT_ID, 12'd3);
    ask(tlca_pkg::ROOT_ID, tlca_pkg::ROOT_ID);
    ask(12'd4095, 12'd4095);
    ask(12'd2, 12'd3);
    ask(12'd2048, 12'd4095);
    ask(12'd4095, 12'd2048);
    ask(12'd3, 12'd2048);
    ask(12'd2048, tlca_pkg::ROOT_ID);
    plant(12'd2, tlca_pkg::ROOT_ID);
    ask(tlca_pkg::ROOT_ID, 12'd2048);
    plant(12'd3, 12'd2048);
    ask(12'd2048, 12'd2);
    ask(12'd2048, 12'd3);
    plant(12'd2, 12'd2);
    ask(12'd2, 12'd2048);
    ask(12'd2, 12'd4095);
    plant(12'd2048, 12'h555);
    plant(12'h555, 12'hAAA);
    ask(12'hAAA, 12'd3);
    ask(12'hAAA, 12'h555);

    // Random: mostly growing the tree and querying it, with overwrites,
    // self-adds and root adds mixed in. A stretch in the middle runs flat out.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 120 && i < 220);
      r = $urandom_range(0, 99);
      if (r < 35 && members.size() < 3000) begin
        plant(member_recent(), fresh_id());
      end else if (r < 45 && members.size() < 3000) begin
        plant(member_any(), fresh_id());
      end else if (r < 50) begin
        plant(member_any(), member_any());
      end else if (r < 53) begin
        qa = member_any();
        plant(qa, qa);
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            qa = member_any();
            qb = member_any();
          end
          1: begin
            qa = member_recent();
            qb = climb(qa, $urandom_range(0, 40));
          end
          2: begin
            qa = member_any();
            qb = qa;
          end
          default: begin
            qa = member_recent();
            qb = member_recent();
          end
        endcase
        if ($urandom_range(0, 1) == 1) begin
          ask(qb, qa);
        end else begin
          ask(qa, qb);
        end
      end
    end
    steady = 1'b0;

    // A long path exercises the higher lifting levels; query across it.
    tail = member_recent();
    for (int i = 0; i < CHAIN_LEN; i++) begin
      qb = fresh_id();
      plant(tail, qb);
      chain.insert(chain.size(), qb);
      tail = qb;
    end
    for (int i = 0; i < 16; i++) begin
      qa = chain[$urandom_range(0, CHAIN_LEN - 1)];
      qb = (i % 2 == 0) ? member_any() : chain[$urandom_range(0, CHAIN_LEN - 1)];
      ask(qa, qb);
    end

    // Repeated self-adds cut the path's end loose and deepen it step by step;
    // nodes hung below it then resolve to it from every direction.
    for (int i = 0; i < SELF_ADDS; i++) begin
      plant(tail, tail);
    end
    kid = fresh_id();
    plant(tail, kid);
    grandkid = fresh_id();
    plant(kid, grandkid);
    ask(tail, kid);
    ask(kid, tail);
    ask(grandkid, tail);
    ask(grandkid, tlca_pkg::ROOT_ID);
    ask(kid, chain[CHAIN_LEN / 2]);
    for (int i = 0; i < 10; i++) begin
      ask(grandkid, member_any());
    end

    in_valid <= 1'b0;

    // Drain: every owed result, then a margin for anything spurious.
    @(negedge clk);
    while (waiting != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d adds and %0d queries; %0d ancestor results compared.",
             adds_sent, queries_sent, compared);
    $display("Included a %0d-node path and %0d self-adds at its end.",
             CHAIN_LEN, SELF_ADDS);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
